[src/stable_sorted_priority_queue_core_defines.svh]
// assertion macros of the sorted priority queue, used by the datapath
`ifndef STABLE_SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SSPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sspq assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sspq assertion failed");

`endif

[src/sspq_pkg.sv]
// shared types and constants of the sorted priority queue
`timescale 1ns / 1ps

package sspq_pkg;

    localparam int CAPACITY       = 16;
    localparam int VALUE_WIDTH    = 32;
    localparam int PRIORITY_WIDTH = 16;
    localparam int COUNT_W        = $clog2(CAPACITY + 1);

    localparam int S_TDATA_W = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = ((VALUE_WIDTH + PRIORITY_WIDTH + COUNT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 3;

    typedef logic [VALUE_WIDTH-1:0]           t_value;
    typedef logic signed [PRIORITY_WIDTH-1:0] t_prio;
    typedef logic [COUNT_W-1:0]               t_count;

    typedef enum logic {
        FUNC_ENQUEUE = 1'b0,
        FUNC_DEQUEUE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_valid;
    } t_dp_status;

endpackage

[src/sspq_ctrl.sv]
// controller state machine of the sorted priority queue
`timescale 1ns / 1ps

module sspq_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic                   i_m_tready,
    input  sspq_pkg::t_dp_status   i_status,
    output sspq_pkg::t_ctrl_cmd    o_cmd
);

    sspq_pkg::t_state r_state;
    sspq_pkg::t_state n_state;

    // input is taken when idle and the result register is free or draining
    assign o_s_tready = (r_state == sspq_pkg::S_IDLE)
                        && (!i_status.out_valid || i_m_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sspq_pkg::S_IDLE: begin
                if (i_s_tvalid && o_s_tready) begin
                    n_state = sspq_pkg::S_EXEC;
                end
            end
            sspq_pkg::S_EXEC: begin
                n_state = sspq_pkg::S_IDLE;
            end
            default: begin
                n_state = sspq_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            sspq_pkg::S_IDLE: begin
                o_cmd.load = i_s_tvalid && o_s_tready;
            end
            sspq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sspq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/sspq_datapath.sv]
// slot array, insertion compares and result register of the priority queue
`timescale 1ns / 1ps
`include "stable_sorted_priority_queue_core_defines.svh"

module sspq_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sspq_pkg::t_ctrl_cmd               i_cmd,
    output sspq_pkg::t_dp_status              o_status,
    input  logic [sspq_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic [sspq_pkg::S_TUSER_W-1:0]    i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [sspq_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic [sspq_pkg::M_TUSER_W-1:0]    o_m_tuser
);

    localparam int CAP = sspq_pkg::CAPACITY;
    localparam int VW  = sspq_pkg::VALUE_WIDTH;
    localparam int PW  = sspq_pkg::PRIORITY_WIDTH;
    localparam int CW  = sspq_pkg::COUNT_W;
    localparam int PAD = sspq_pkg::M_TDATA_W - VW - PW - CW;

    // captured transaction
    sspq_pkg::t_func   r_func;
    sspq_pkg::t_value  r_value;
    sspq_pkg::t_prio   r_prio;

    // slot array, slot 0 at the front
    sspq_pkg::t_value  r_slot_value [CAP];
    sspq_pkg::t_prio   r_slot_prio  [CAP];
    sspq_pkg::t_value  n_slot_value [CAP];
    sspq_pkg::t_prio   n_slot_prio  [CAP];
    sspq_pkg::t_count  r_count;
    sspq_pkg::t_count  n_count;

    // result register
    logic              r_out_valid;
    sspq_pkg::t_value  r_out_value;
    sspq_pkg::t_prio   r_out_prio;
    sspq_pkg::t_count  r_out_count;
    logic              r_out_empty;
    sspq_pkg::t_status r_out_status;
    sspq_pkg::t_status n_status;

    logic [CAP-1:0]    ge;
    logic [CAP-1:0]    prev_ge;
    logic              is_full;
    logic              is_none;

    // parallel compares: stored entry occupied and not below the new priority
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            ge[i] = (CW'(i) < r_count) && (r_slot_prio[i] >= r_prio);
        end
    end

    assign prev_ge = {ge[CAP-2:0], 1'b1};
    assign is_full = (r_count == CW'(CAP));
    assign is_none = (r_count == '0);

    // next cell values, count and status: enqueue keeps, takes the new entry or shifts back; dequeue shifts forward
    always_comb begin
        n_slot_value = r_slot_value;
        n_slot_prio  = r_slot_prio;
        n_count      = r_count;
        n_status     = sspq_pkg::ST_OK;
        if (r_func == sspq_pkg::FUNC_ENQUEUE) begin
            if (is_full) begin
                n_status = sspq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
                for (int i = 0; i < CAP; i++) begin
                    if (ge[i]) begin
                        n_slot_value[i] = r_slot_value[i];
                        n_slot_prio[i]  = r_slot_prio[i];
                    end else if (prev_ge[i]) begin
                        n_slot_value[i] = r_value;
                        n_slot_prio[i]  = r_prio;
                    end else if (i > 0) begin
                        n_slot_value[i] = r_slot_value[(i + CAP - 1) % CAP];
                        n_slot_prio[i]  = r_slot_prio[(i + CAP - 1) % CAP];
                    end
                end
            end
        end else begin
            if (is_none) begin
                n_status = sspq_pkg::ST_EMPTY;
            end else begin
                n_count = r_count - CW'(1);
                for (int i = 0; i < CAP - 1; i++) begin
                    n_slot_value[i] = r_slot_value[i + 1];
                    n_slot_prio[i]  = r_slot_prio[i + 1];
                end
            end
        end
    end

    // capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= sspq_pkg::t_func'(i_s_tuser[0]);
            r_value <= i_s_tdata[VW-1:0];
            r_prio  <= i_s_tdata[VW+PW-1:VW];
        end
    end

    // slot array update
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_slot_value <= n_slot_value;
            r_slot_prio  <= n_slot_prio;
        end
    end

    // occupancy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // result payload, zero front fields when empty
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_count  <= n_count;
            r_out_status <= n_status;
            r_out_empty  <= (n_count == '0);
            r_out_value  <= (n_count == '0) ? '0 : n_slot_value[0];
            r_out_prio   <= (n_count == '0) ? '0 : n_slot_prio[0];
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            priority if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD{1'b0}}, r_out_count, r_out_prio, r_out_value};
    assign o_m_tuser  = {r_out_status, r_out_empty};

    // checks
    `SSPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAP))
    `SSPQ_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, i_cmd.exec, r_out_valid)
    `SSPQ_ASSERT_NEXT(a_full_keeps_count, i_clk, i_rst_n,
        i_cmd.exec && r_func == sspq_pkg::FUNC_ENQUEUE && is_full, r_count == $past(r_count))
    `SSPQ_ASSERT_NOW(a_exec_result_free, i_clk, i_rst_n, i_cmd.exec, !r_out_valid)
    `SSPQ_ASSERT_NOW(a_status_full_count, i_clk, i_rst_n,
        r_out_valid && r_out_status == sspq_pkg::ST_FULL, r_out_count == CW'(CAP))

endmodule

[src/stable_sorted_priority_queue_core.sv]
// Stable sorted priority queue, top level.
// Slave channel (i_s_*) carries one operation per transaction: enqueue of a
// value and signed priority, or dequeue of the front entry. Master channel
// (o_m_*) returns one result per operation: the new front value and
// priority (zero when empty), the entry count, an empty flag and a status
// (ok, enqueue rejected because full, dequeue on empty).
// Entries sit in a shift array of CAPACITY cells; an enqueue compares the
// new priority against every cell at once and lands behind all entries of
// greater or equal priority, so equal priorities leave in arrival order.
// The accepted operation is captured, the controller updates the array and
// the result register is loaded; a new operation is accepted only in the
// idle state, so none is taken while the last one is in its array update.
// A finished result waits in an output register; the next operation is
// accepted in the cycle the receiver takes it, so a stalled receiver holds
// the block after at most one buffered result.
// Reset (i_rst_n low, synchronous) empties the queue and drops any pending
// result; no clearing pass is needed.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // entry_value, entry_priority
    input  logic [sspq_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // func
    input  logic [sspq_pkg::S_TUSER_W-1:0]    i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // head_value, head_priority, entry_count, zero fill
    output logic [sspq_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // is_empty, status
    output logic [sspq_pkg::M_TUSER_W-1:0]    o_m_tuser
);

    sspq_pkg::t_ctrl_cmd  cmd;
    sspq_pkg::t_dp_status status;

    // controller
    sspq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    sspq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
